/* rtl/tekd_pkg.sv */
// Package for the terminal escape key decoder.
// Holds phase and key kind types, character constants and item structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tekd_pkg;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ESC     = 2'd1,
      PH_BRACKET = 2'd2,
      PH_DIGITS  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KK_PLAIN = 3'd0,
      KK_UP    = 3'd1,
      KK_DOWN  = 3'd2,
      KK_PGUP  = 3'd3,
      KK_PGDN  = 3'd4,
      KK_HOME  = 3'd5,
      KK_END   = 3'd6,
      KK_NONE  = 3'd7
   } key_kind_type;

   localparam logic [7:0] CH_ESC     = 8'd27;
   localparam logic [7:0] CH_BRACKET = 8'h5b;  // '['
   localparam logic [7:0] CH_UP      = 8'h41;  // 'A'
   localparam logic [7:0] CH_DOWN    = 8'h42;  // 'B'
   localparam logic [7:0] CH_HOME    = 8'h48;  // 'H'
   localparam logic [7:0] CH_END     = 8'h46;  // 'F'
   localparam logic [7:0] CH_TILDE   = 8'h7e;  // '~'
   localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
   localparam logic [7:0] ACC_MAX    = 8'd255;

   // timeout flag in the cmd field
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_value;
   } req_item_type;

   typedef struct packed {
      logic         emit;
      key_kind_type kind;
      logic [7:0]   key_byte;
   } result_type;

   // number before '~' to key kind
   function automatic key_kind_type map_number(input logic [7:0] v);
      key_kind_type k;
      case (v)
         8'd5:    k = KK_PGUP;
         8'd6:    k = KK_PGDN;
         8'd1:    k = KK_HOME;
         8'd7:    k = KK_HOME;
         8'd4:    k = KK_END;
         8'd8:    k = KK_END;
         default: k = KK_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

/* rtl/tekd_if.sv */
// Valid/ready channel interfaces for the key decoder: byte/timeout in, key out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tekd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] byte_value;

   modport source (output valid, output cmd, output byte_value, input ready);
   modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

interface tekd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] key_kind;
   logic [7:0] key_byte;

   modport source (output valid, output key_kind, output key_byte, input ready);
   modport sink   (input valid, input key_kind, input key_byte, output ready);
endinterface

`default_nettype wire

/* rtl/tekd_decode.sv */
// Escape sequence state machine: phase and digit accumulator registers,
// next state and result logic. Depends on tekd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tekd_decode (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        step,
   input  wire tekd_pkg::req_item_type item,
   output tekd_pkg::result_type       result
);

   tekd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          acc_ff, acc_in;

   logic        timeout;
   logic [7:0]  b;
   logic        digit;
   logic [3:0]  digit_val;
   logic [11:0] acc_next_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tekd_pkg::PH_IDLE;
         acc_ff   <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   assign timeout   = (item.cmd == tekd_pkg::CMD_TIMEOUT);
   assign b         = item.byte_value;
   assign digit     = (b >= tekd_pkg::CH_ZERO) && (b <= tekd_pkg::CH_NINE);
   assign digit_val = 4'(b - tekd_pkg::CH_ZERO);
   // acc * 10 + digit, as shifts
   assign acc_next_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {8'd0, digit_val};

   always_comb begin
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      result.emit     = 1'b0;
      result.kind     = tekd_pkg::KK_PLAIN;
      result.key_byte = 8'd0;
      case (phase_ff)
         tekd_pkg::PH_IDLE: begin
            if (!timeout) begin
               if (b == tekd_pkg::CH_ESC) begin
                  phase_in = tekd_pkg::PH_ESC;
               end else begin
                  result.emit     = 1'b1;
                  result.key_byte = b;
               end
            end
         end
         tekd_pkg::PH_ESC: begin
            if (!timeout && b == tekd_pkg::CH_BRACKET) begin
               phase_in = tekd_pkg::PH_BRACKET;
            end else begin
               // lone ESC; the byte after it is dropped
               phase_in        = tekd_pkg::PH_IDLE;
               result.emit     = 1'b1;
               result.key_byte = tekd_pkg::CH_ESC;
            end
         end
         tekd_pkg::PH_BRACKET: begin
            if (timeout) begin
               phase_in        = tekd_pkg::PH_IDLE;
               result.emit     = 1'b1;
               result.key_byte = tekd_pkg::CH_ESC;
            end else if (digit) begin
               acc_in   = {4'd0, digit_val};
               phase_in = tekd_pkg::PH_DIGITS;
            end else begin
               phase_in    = tekd_pkg::PH_IDLE;
               result.emit = 1'b1;
               case (b)
                  tekd_pkg::CH_UP:   result.kind = tekd_pkg::KK_UP;
                  tekd_pkg::CH_DOWN: result.kind = tekd_pkg::KK_DOWN;
                  tekd_pkg::CH_HOME: result.kind = tekd_pkg::KK_HOME;
                  tekd_pkg::CH_END:  result.kind = tekd_pkg::KK_END;
                  default:           result.kind = tekd_pkg::KK_NONE;
               endcase
            end
         end
         tekd_pkg::PH_DIGITS: begin
            if (timeout) begin
               phase_in    = tekd_pkg::PH_IDLE;
               result.emit = 1'b1;
               result.kind = tekd_pkg::KK_NONE;
            end else if (digit) begin
               acc_in = (acc_next_wide > {4'd0, tekd_pkg::ACC_MAX}) ?
                        tekd_pkg::ACC_MAX : acc_next_wide[7:0];
            end else begin
               phase_in    = tekd_pkg::PH_IDLE;
               result.emit = 1'b1;
               result.kind = (b == tekd_pkg::CH_TILDE) ?
                             tekd_pkg::map_number(acc_ff) : tekd_pkg::KK_NONE;
            end
         end
         default: begin
            phase_in = tekd_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/tekd_out_reg.sv */
// Result register driving the key channel; holds a key while the sink stalls.
// Depends on tekd_pkg and tekd_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module tekd_out_reg (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       load,
   input  wire tekd_pkg::result_type result,
   output logic                      can_take,
   tekd_rsp_if.source                rsp_chan
);

   logic                  valid_ff, valid_in;
   tekd_pkg::key_kind_type kind_ff;
   logic [7:0]            byte_ff;

   assign can_take = !valid_ff || rsp_chan.ready;
   assign valid_in = (load && result.emit) || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.emit) begin
         kind_ff <= result.kind;
         byte_ff <= result.key_byte;
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.key_kind = kind_ff;
   assign rsp_chan.key_byte = byte_ff;

endmodule

`default_nettype wire

/* rtl/terminal_escape_key_decoder_top.sv */
// Terminal escape key decoder, top level: input register, decoder, result register.
// Depends on tekd_pkg, tekd_if, tekd_decode and tekd_out_reg.
//
// Usage:
//   req_chan carries one item per handshake: cmd (0 = byte arrived,
//   1 = inter-byte timeout) and byte_value. An item is taken at a rising
//   clock edge with valid and ready both high.
//   rsp_chan carries keys: key_kind (0 plain .. 7 none) and key_byte,
//   which is the byte for plain keys and zero otherwise.
//   An item yields zero or one key; ESC and partial sequences yield none
//   until the sequence finishes or times out.
// Path: an accepted item sits in the input register and is decoded into the
//   result register once that register can take it; its key is then valid on
//   rsp_chan and is held there until it is taken.
// Throughput: one item per cycle while rsp_chan does not stall, set by the
//   phase and accumulator update in the decoder.
// Reset (synchronous, active high): phase idle, accumulator zero, both
//   stage registers empty. No clearing pass.
// Stall: while a key waits in the result register and rsp_chan.ready is
//   low, the input register holds its item and req_chan.ready drops once
//   it is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module terminal_escape_key_decoder_top (
   input  wire        clock,
   input  wire        reset,
   tekd_req_if.sink   req_chan,
   tekd_rsp_if.source rsp_chan
);

   // input register stage
   logic                   in_valid_ff, in_valid_in;
   tekd_pkg::req_item_type in_item_ff;

   logic                 can_take;
   logic                 advance;   // decoder consumes the held item
   logic                 req_take;
   tekd_pkg::result_type result;

   assign advance        = in_valid_ff && can_take;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd        <= req_chan.cmd;
         in_item_ff.byte_value <= req_chan.byte_value;
      end
   end

   // phase machine and key selection
   tekd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // result register toward the key sink
   tekd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* test/tb_terminal_escape_key_decoder_top.sv */
// Testbench for terminal_escape_key_decoder_top: drives bytes and timeouts and checks every key.
// A scoreboard class predicts keys on the fly; depends on tekd_pkg, tekd_if and the RTL.
`timescale 1ns / 1ps

module tb_terminal_escape_key_decoder_top;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES  = 10;      // two-stage pipe, plus margin
   localparam int ITEMS_PER_LEG = 633;     // three legs, ~1900 items

   typedef struct packed {
      tekd_pkg::key_kind_type kind;
      logic [7:0]             key_byte;
   } expected_key_type;

   // Tracks the decoder phase and digit value, queues the keys it should emit.
   class key_scoreboard;
      tekd_pkg::phase_type phase;
      logic [7:0]          number;
      expected_key_type    pending[$];
      int                  mismatches;

      function new();
         phase      = tekd_pkg::PH_IDLE;
         number     = '0;
         mismatches = 0;
      endfunction

      function void push_key(tekd_pkg::key_kind_type kind, logic [7:0] kb);
         expected_key_type e;
         e.kind     = kind;
         e.key_byte = kb;
         pending.push_back(e);
      endfunction

      function tekd_pkg::key_kind_type tilde_key(logic [7:0] n);
         tekd_pkg::key_kind_type k;
         case (n)
            8'd5:       k = tekd_pkg::KK_PGUP;
            8'd6:       k = tekd_pkg::KK_PGDN;
            8'd1, 8'd7: k = tekd_pkg::KK_HOME;
            8'd4, 8'd8: k = tekd_pkg::KK_END;
            default:    k = tekd_pkg::KK_NONE;
         endcase
         return k;
      endfunction

      function void note_input(logic cmd, logic [7:0] b);
         bit is_digit;
         int v;
         is_digit = (b >= tekd_pkg::CH_ZERO) && (b <= tekd_pkg::CH_NINE);
         case (phase)
            tekd_pkg::PH_IDLE: begin
               // timeout while idle: nothing happens
               if (cmd == tekd_pkg::CMD_BYTE) begin
                  if (b == tekd_pkg::CH_ESC) phase = tekd_pkg::PH_ESC;
                  else push_key(tekd_pkg::KK_PLAIN, b);
               end
            end
            tekd_pkg::PH_ESC: begin
               if (cmd == tekd_pkg::CMD_BYTE && b == tekd_pkg::CH_BRACKET) begin
                  phase = tekd_pkg::PH_BRACKET;
               end else begin
                  // lone ESC; a following byte is swallowed
                  phase = tekd_pkg::PH_IDLE;
                  push_key(tekd_pkg::KK_PLAIN, tekd_pkg::CH_ESC);
               end
            end
            tekd_pkg::PH_BRACKET: begin
               if (cmd == tekd_pkg::CMD_TIMEOUT) begin
                  phase = tekd_pkg::PH_IDLE;
                  push_key(tekd_pkg::KK_PLAIN, tekd_pkg::CH_ESC);
               end else if (is_digit) begin
                  number = b - tekd_pkg::CH_ZERO;
                  phase  = tekd_pkg::PH_DIGITS;
               end else begin
                  phase = tekd_pkg::PH_IDLE;
                  case (b)
                     tekd_pkg::CH_UP:   push_key(tekd_pkg::KK_UP, '0);
                     tekd_pkg::CH_DOWN: push_key(tekd_pkg::KK_DOWN, '0);
                     tekd_pkg::CH_HOME: push_key(tekd_pkg::KK_HOME, '0);
                     tekd_pkg::CH_END:  push_key(tekd_pkg::KK_END, '0);
                     default:           push_key(tekd_pkg::KK_NONE, '0);
                  endcase
               end
            end
            default: begin
               if (cmd == tekd_pkg::CMD_TIMEOUT) begin
                  phase = tekd_pkg::PH_IDLE;
                  push_key(tekd_pkg::KK_NONE, '0);
               end else if (is_digit) begin
                  v = int'(number) * 10 + int'(b) - int'(tekd_pkg::CH_ZERO);
                  number = (v > 255) ? tekd_pkg::ACC_MAX : v[7:0];
               end else begin
                  phase = tekd_pkg::PH_IDLE;
                  if (b != tekd_pkg::CH_TILDE) push_key(tekd_pkg::KK_NONE, '0);
                  else push_key(tilde_key(number), '0);
               end
            end
         endcase
      endfunction

      function void check_result(logic [2:0] kind, logic [7:0] kb);
         expected_key_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected key: kind %0d byte %02h", kind, kb);
            return;
         end
         e = pending.pop_front();
         if (kind !== e.kind || kb !== e.key_byte) begin
            mismatches++;
            if (mismatches <= 10)
               $display("key mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                        e.kind, e.key_byte, kind, kb);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tekd_req_if req_if ();
   tekd_rsp_if rsp_if ();

   terminal_escape_key_decoder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   key_scoreboard keys = new();

   int send_idle_pct = 0;  // chance per item slot that the sender holds off
   int recv_idle_pct = 0;  // chance per cycle that the receiver stalls
   int cycle_count   = 0;
   int sent_count    = 0;

   tekd_pkg::req_item_type burst[$];  // one random sequence, sent back to back

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Receiver: random stalls on the key channel.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: every handshake on either side goes to the scoreboard.
   // Signals are read at the edge, before any nonblocking update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            keys.note_input(req_if.cmd, req_if.byte_value);
         if (rsp_if.valid && rsp_if.ready)
            keys.check_result(rsp_if.key_kind, rsp_if.key_byte);
      end
   end

   // Watchdog: a hung pipe ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** terminal_escape_key_decoder_top: FAILED **");
         $finish;
      end
   end

   // One item: optional random hold-off, then hold valid until it is taken.
   // Valid stays high into the next item unless that item starts with a gap.
   task automatic send_item(input logic cmd, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= cmd;
      req_if.byte_value <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_item(burst[i].cmd, burst[i].byte_value);
      sent_count += burst.size();
      burst.delete();
   endtask

   function automatic logic [7:0] rand_digit();
      logic [7:0] common_digits[6] = '{8'h31, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38};
      // mostly digits that name a key, the rest anything 0..9
      if ($urandom_range(99) < 60) return common_digits[$urandom_range(5)];
      return tekd_pkg::CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_letter();
      case ($urandom_range(3))
         0:       return tekd_pkg::CH_UP;
         1:       return tekd_pkg::CH_DOWN;
         2:       return tekd_pkg::CH_HOME;
         default: return tekd_pkg::CH_END;
      endcase
   endfunction

   function automatic tekd_pkg::req_item_type rand_timeout();
      tekd_pkg::req_item_type t;
      t.cmd        = tekd_pkg::CMD_TIMEOUT;
      t.byte_value = 8'($urandom_range(255));  // ignored, but toggled anyway
      return t;
   endfunction

   function automatic tekd_pkg::req_item_type byte_item(logic [7:0] b);
      tekd_pkg::req_item_type t;
      t.cmd        = tekd_pkg::CMD_BYTE;
      t.byte_value = b;
      return t;
   endfunction

   // Builds one random sequence in burst: well-formed escape sequences,
   // broken ones, timeouts and raw noise.
   task automatic build_random_sequence();
      int pick;
      int digits;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 12) begin
         b = 8'($urandom_range(255));
         if (b == tekd_pkg::CH_ESC) b = 8'hff;
         burst.push_back(byte_item(b));
      end else if (pick < 27) begin
         burst.push_back(byte_item(tekd_pkg::CH_ESC));
         burst.push_back(byte_item(tekd_pkg::CH_BRACKET));
         burst.push_back(byte_item(rand_letter()));
      end else if (pick < 57) begin
         burst.push_back(byte_item(tekd_pkg::CH_ESC));
         burst.push_back(byte_item(tekd_pkg::CH_BRACKET));
         // a few long runs drive the digit value into saturation
         digits = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
         repeat (digits) burst.push_back(byte_item(rand_digit()));
         pick = $urandom_range(99);
         if (pick < 85) burst.push_back(byte_item(tekd_pkg::CH_TILDE));
         else if (pick < 90) burst.push_back(rand_timeout());
         else burst.push_back(byte_item(8'($urandom_range(255))));
      end else if (pick < 65) begin
         // ESC then timeout or a stray byte (a '[' here keeps the sequence open)
         burst.push_back(byte_item(tekd_pkg::CH_ESC));
         if ($urandom_range(1)) burst.push_back(rand_timeout());
         else burst.push_back(byte_item(8'($urandom_range(255))));
      end else if (pick < 73) begin
         burst.push_back(byte_item(tekd_pkg::CH_ESC));
         burst.push_back(byte_item(tekd_pkg::CH_BRACKET));
         if ($urandom_range(1)) burst.push_back(rand_timeout());
         else burst.push_back(byte_item(8'($urandom_range(255))));
      end else if (pick < 80) begin
         // timeout from idle is ignored by the block, so it is not counted
         send_item(tekd_pkg::CMD_TIMEOUT, 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(3) == 0) burst.push_back(rand_timeout());
            else burst.push_back(byte_item(8'($urandom_range(255))));
         end
      end
   endtask

   initial begin
      int leg;
      int target;

      // every input known from time zero
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.cmd        = tekd_pkg::CMD_BYTE;
      req_if.byte_value = '0;
      rsp_if.ready      = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 55;

      // Directed part: byte extreme, idle timeout, ESC cut short three ways, unknown
      // letter, a full page-up, a number past saturation and a timeout in a digit run.
      send_item(tekd_pkg::CMD_BYTE, 8'hff);
      send_item(tekd_pkg::CMD_TIMEOUT, 8'h00);      // ignored while idle
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_TIMEOUT, 8'hff);      // lone ESC by timeout
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, 8'h78);         // 'x' swallowed, ESC out
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BRACKET);
      send_item(tekd_pkg::CMD_TIMEOUT, 8'h00);      // ESC [ then timeout gives ESC
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BRACKET);
      send_item(tekd_pkg::CMD_BYTE, 8'h5a);         // 'Z': none
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BRACKET);
      send_item(tekd_pkg::CMD_BYTE, 8'h35);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_TILDE);      // page up
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BRACKET);
      send_item(tekd_pkg::CMD_BYTE, 8'h32);
      send_item(tekd_pkg::CMD_BYTE, 8'h35);
      send_item(tekd_pkg::CMD_BYTE, 8'h36);         // 256 saturates to 255
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_TILDE);      // none
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      send_item(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BRACKET);
      send_item(tekd_pkg::CMD_BYTE, 8'h33);
      send_item(tekd_pkg::CMD_TIMEOUT, 8'h00);      // timeout inside digit run: none

      // Random part in three legs: sender-heavy idling, receiver-heavy, none.
      for (leg = 0; leg < 3; leg++) begin
         case (leg)
            0: begin send_idle_pct = 38; recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 38; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = sent_count + ITEMS_PER_LEG;
         while (sent_count < target) begin
            build_random_sequence();
            send_burst();
         end
      end

      // all stimulus taken at this edge; drop valid once
      req_if.valid <= 1'b0;

      while (keys.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (keys.pending.size() != 0)
         $display("%0d expected keys never arrived", keys.pending.size());

      if (keys.mismatches == 0 && keys.pending.size() == 0) begin
         $display("** terminal_escape_key_decoder_top: PASSED **");
      end else begin
         $display("** terminal_escape_key_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/tekd_pkg.sv
rtl/tekd_if.sv
rtl/tekd_decode.sv
rtl/tekd_out_reg.sv
rtl/terminal_escape_key_decoder_top.sv
test/tb_terminal_escape_key_decoder_top.sv
